@@ src/mbt_pkg.sv @@
package mbt_pkg;

    // Image limits and field widths
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int PIXEL_BITS = 24;
    localparam int COORD_W    = 8;
    localparam int DIM_W      = 9;
    localparam int ADDR_W     = 2 * COORD_W;
    localparam int STEP_W     = 4;

    localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);

    // Configuration register indexes
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // Input operation codes
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // Result status codes
    localparam logic [1:0] STS_POINT = 2'd0;
    localparam logic [1:0] STS_EMPTY = 2'd1;
    localparam logic [1:0] STS_DONE  = 2'd2;

    // Trace phase
    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_TRACING = 4'b0010,
        PH_DONE    = 4'b0100,
        PH_EMPTY   = 4'b1000
    } phase_t;

    typedef logic [STEP_W-1:0] step_t;

    // Microprogram addresses
    localparam step_t SEQ_FETCH  = 4'd0;
    localparam step_t SEQ_START  = 4'd1;
    localparam step_t SEQ_CHECK  = 4'd2;
    localparam step_t SEQ_SETUP  = 4'd3;
    localparam step_t SEQ_PROBE  = 4'd4;
    localparam step_t SEQ_MISS   = 4'd5;
    localparam step_t SEQ_HIT    = 4'd6;
    localparam step_t SEQ_POINT  = 4'd7;
    localparam step_t SEQ_STATUS = 4'd8;

    // Datapath actions
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_ACCEPT,
        ACT_START,
        ACT_SETUP,
        ACT_PROBE,
        ACT_RETURN,
        ACT_MOVE,
        ACT_POINT,
        ACT_STATUS
    } act_t;

    // Jump conditions
    typedef enum logic [1:0] {
        JMP_NEVER,
        JMP_ALWAYS,
        JMP_NOT_TRACING,
        JMP_HIT
    } jump_t;

    // Hold conditions
    typedef enum logic [1:0] {
        WT_NONE,
        WT_NO_REQ,
        WT_PROBE,
        WT_OUT_FULL
    } wait_t;

    typedef struct packed {
        act_t  act;
        jump_t jump;
        wait_t wt;
        step_t target;
    } uword_t;

    // Status from datapath to sequencer
    typedef struct packed {
        logic req_seen;
        logic not_tracing;
        logic hit;
        logic probe_busy;
        logic out_full;
    } flags_t;

    // Neighbor offsets by direction, west first, then counterclockwise with y growing down
    function automatic logic signed [1:0] dir_dx(input logic [2:0] d);
        logic signed [1:0] r;
        case (d)
            3'd0: r = -2'sd1;
            3'd1: r = -2'sd1;
            3'd2: r = 2'sd0;
            3'd3: r = 2'sd1;
            3'd4: r = 2'sd1;
            3'd5: r = 2'sd1;
            3'd6: r = 2'sd0;
            default: r = -2'sd1;
        endcase
        return r;
    endfunction

    function automatic logic signed [1:0] dir_dy(input logic [2:0] d);
        logic signed [1:0] r;
        case (d)
            3'd0: r = 2'sd0;
            3'd1: r = 2'sd1;
            3'd2: r = 2'sd1;
            3'd3: r = 2'sd1;
            3'd4: r = 2'sd0;
            3'd5: r = -2'sd1;
            3'd6: r = -2'sd1;
            default: r = -2'sd1;
        endcase
        return r;
    endfunction

    // Zero acts as one, anything above the maximum acts as the maximum
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] lim);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > lim)
            r = lim;
        else
            r = v;
        return r;
    endfunction

endpackage

@@ src/mbt_ucode_rom.sv @@
module mbt_ucode_rom
    import mbt_pkg::*;
(
    input  step_t  step,
    output uword_t word
);

    // Control store: one word per step
    always_comb
    begin
        case (step)
            SEQ_FETCH:  word = '{ACT_ACCEPT, JMP_NEVER,       WT_NO_REQ,   SEQ_FETCH};
            SEQ_START:  word = '{ACT_START,  JMP_NEVER,       WT_NONE,     SEQ_FETCH};
            SEQ_CHECK:  word = '{ACT_NONE,   JMP_NOT_TRACING, WT_NONE,     SEQ_STATUS};
            SEQ_SETUP:  word = '{ACT_SETUP,  JMP_NEVER,       WT_NONE,     SEQ_FETCH};
            SEQ_PROBE:  word = '{ACT_PROBE,  JMP_HIT,         WT_PROBE,    SEQ_HIT};
            SEQ_MISS:   word = '{ACT_RETURN, JMP_ALWAYS,      WT_NONE,     SEQ_POINT};
            SEQ_HIT:    word = '{ACT_MOVE,   JMP_NEVER,       WT_NONE,     SEQ_FETCH};
            SEQ_POINT:  word = '{ACT_POINT,  JMP_ALWAYS,      WT_OUT_FULL, SEQ_FETCH};
            SEQ_STATUS: word = '{ACT_STATUS, JMP_ALWAYS,      WT_OUT_FULL, SEQ_FETCH};
            default:    word = '{ACT_NONE,   JMP_ALWAYS,      WT_NONE,     SEQ_FETCH};
        endcase
    end

endmodule

@@ src/mbt_sequencer.sv @@
module mbt_sequencer
    import mbt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  flags_t flags,
    output act_t   act
);

    step_t  step_reg;
    step_t  step_next;
    uword_t word;
    logic   hold;
    logic   take;

    mbt_ucode_rom u_rom (
        .step (step_reg),
        .word (word)
    );

    // Evaluate hold and jump conditions of the current word
    always_comb
    begin
        case (word.wt)
            WT_NO_REQ:   hold = !flags.req_seen;
            WT_PROBE:    hold = flags.probe_busy;
            WT_OUT_FULL: hold = flags.out_full;
            default:     hold = 1'b0;
        endcase
        case (word.jump)
            JMP_ALWAYS:      take = 1'b1;
            JMP_NOT_TRACING: take = flags.not_tracing;
            JMP_HIT:         take = flags.hit;
            default:         take = 1'b0;
        endcase
        if (hold)
            step_next = step_reg;
        else if (take)
            step_next = word.target;
        else
            step_next = step_reg + STEP_W'(1);
    end

    assign act = word.act;

    // Advance the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= SEQ_FETCH;
        else
            step_reg <= step_next;
    end

endmodule

@@ src/mbt_datapath.sv @@
module mbt_datapath
    import mbt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  act_t                  act,
    output flags_t                flags,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_op,
    input  logic [PIXEL_BITS-1:0] in_pixel,
    input  logic                  cfg_we,
    input  logic                  cfg_idx,
    input  logic [DIM_W-1:0]      cfg_val,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COORD_W-1:0]    out_x,
    output logic [COORD_W-1:0]    out_y,
    output logic                  out_closing,
    output logic [1:0]            out_status
);

    // Configuration and load state
    logic [DIM_W-1:0]      width_reg;
    logic [DIM_W-1:0]      height_reg;
    logic [PIXEL_BITS-1:0] bg_reg;
    logic [COORD_W-1:0]    load_x_reg;
    logic [DIM_W-1:0]      load_y_reg;
    logic                  first_valid_reg;
    logic [COORD_W-1:0]    first_x_reg;
    logic [COORD_W-1:0]    first_y_reg;
    phase_t                phase_reg;

    // Trace state
    logic [COORD_W-1:0]    cur_x_reg;
    logic [COORD_W-1:0]    cur_y_reg;
    logic [COORD_W-1:0]    start_x_reg;
    logic [COORD_W-1:0]    start_y_reg;
    logic [2:0]            dir_reg;

    // Probe pipeline
    logic [3:0]            iss_k_reg;
    logic                  cand_valid_reg;
    logic                  cand_ok_reg;
    logic [COORD_W-1:0]    cand_x_reg;
    logic [COORD_W-1:0]    cand_y_reg;
    logic [2:0]            cand_d_reg;
    logic                  rd_reg;

    // Output slot
    logic                  out_valid_reg;
    logic [COORD_W-1:0]    out_x_reg;
    logic [COORD_W-1:0]    out_y_reg;
    logic                  out_closing_reg;
    logic [1:0]            out_status_reg;

    // Foreground map
    logic                  fg_map [0:(1 << ADDR_W) - 1];

    logic [DIM_W-1:0]      eff_w;
    logic [DIM_W-1:0]      eff_h;
    logic                  accept;
    logic                  load_acc;
    logic                  restart;
    logic [COORD_W-1:0]    lx_eff;
    logic [DIM_W-1:0]      ly_eff;
    logic                  first_valid_eff;
    logic                  full;
    logic                  at_origin;
    logic                  fg_bit;
    logic                  wr_en;
    logic [DIM_W-1:0]      lx_inc;
    logic                  row_end;

    logic                  hit;
    logic                  issue;
    logic [2:0]            probe_d;
    logic signed [1:0]     dx;
    logic signed [1:0]     dy;
    logic [DIM_W:0]        tx;
    logic [DIM_W:0]        ty;
    logic                  in_range;
    logic                  before_load;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  out_free;
    logic                  is_closing;

    assign eff_w = clamp_dim(width_reg, MAX_W_DIM);
    assign eff_h = clamp_dim(height_reg, MAX_H_DIM);

    // Load path: a load after a trace has begun starts a new image
    assign in_ready        = (act == ACT_ACCEPT);
    assign accept          = in_valid && in_ready;
    assign load_acc        = accept && (in_op == OP_LOAD);
    assign restart         = (phase_reg != PH_IDLE);
    assign lx_eff          = restart ? '0 : load_x_reg;
    assign ly_eff          = restart ? '0 : load_y_reg;
    assign first_valid_eff = restart ? 1'b0 : first_valid_reg;
    assign full            = (ly_eff >= eff_h);
    assign at_origin       = (lx_eff == '0) && (ly_eff == '0);
    assign fg_bit          = at_origin ? 1'b0 : (in_pixel != bg_reg);
    assign wr_en           = load_acc && !full;
    assign lx_inc          = {1'b0, lx_eff} + DIM_W'(1);
    assign row_end         = (lx_inc == eff_w);

    // Neighbor candidate for the current probe
    assign hit         = cand_valid_reg && cand_ok_reg && rd_reg;
    assign issue       = (act == ACT_PROBE) && !hit && !iss_k_reg[3];
    assign probe_d     = dir_reg + iss_k_reg[2:0];
    assign dx          = dir_dx(probe_d);
    assign dy          = dir_dy(probe_d);
    assign tx          = {2'b00, cur_x_reg} + {{DIM_W{dx[1]}}, dx[0]};
    assign ty          = {2'b00, cur_y_reg} + {{DIM_W{dy[1]}}, dy[0]};
    assign in_range    = !tx[DIM_W] && !ty[DIM_W]
                         && (tx[DIM_W-1:0] < eff_w) && (ty[DIM_W-1:0] < eff_h);
    assign before_load = (ty[DIM_W-1:0] < load_y_reg)
                         || ((ty[DIM_W-1:0] == load_y_reg)
                             && (tx[DIM_W-1:0] < {1'b0, load_x_reg}));
    assign rd_addr     = {ty[COORD_W-1:0], tx[COORD_W-1:0]};

    assign out_free   = !out_valid_reg || out_ready;
    assign is_closing = (cur_x_reg == start_x_reg) && (cur_y_reg == start_y_reg);

    // Report to the sequencer
    assign flags.req_seen    = accept && (in_op == OP_REQUEST);
    assign flags.not_tracing = (phase_reg != PH_TRACING);
    assign flags.hit         = hit;
    assign flags.probe_busy  = !hit && !(iss_k_reg[3] && cand_valid_reg);
    assign flags.out_full    = !out_free;

    // Map write on load, registered read on probe
    always_ff @(posedge clk)
    begin
        if (wr_en)
            fg_map[{ly_eff[COORD_W-1:0], lx_eff}] <= fg_bit;
        if (issue)
            rd_reg <= fg_map[rd_addr];
    end

    // Configuration, loading and trace phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg       <= MAX_W_DIM;
            height_reg      <= MAX_H_DIM;
            bg_reg          <= '0;
            load_x_reg      <= '0;
            load_y_reg      <= '0;
            first_valid_reg <= 1'b0;
            first_x_reg     <= '0;
            first_y_reg     <= '0;
            phase_reg       <= PH_IDLE;
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            start_x_reg     <= '0;
            start_y_reg     <= '0;
            dir_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_idx == REG_IMAGE_WIDTH)
                    width_reg <= cfg_val;
                else
                    height_reg <= cfg_val;
                load_x_reg      <= '0;
                load_y_reg      <= '0;
                first_valid_reg <= 1'b0;
                phase_reg       <= PH_IDLE;
            end
            else if (load_acc)
            begin
                phase_reg       <= PH_IDLE;
                load_x_reg      <= lx_eff;
                load_y_reg      <= ly_eff;
                first_valid_reg <= first_valid_eff;
                if (!full)
                begin
                    if (at_origin)
                        bg_reg <= in_pixel;
                    if (fg_bit && !first_valid_eff)
                    begin
                        first_valid_reg <= 1'b1;
                        first_x_reg     <= lx_eff;
                        first_y_reg     <= ly_eff[COORD_W-1:0];
                    end
                    if (row_end)
                    begin
                        load_x_reg <= '0;
                        load_y_reg <= ly_eff + DIM_W'(1);
                    end
                    else
                    begin
                        load_x_reg <= lx_inc[COORD_W-1:0];
                    end
                end
            end
            else
            begin
                case (act)
                    ACT_START:
                    begin
                        if (phase_reg == PH_IDLE)
                        begin
                            if (first_valid_reg)
                            begin
                                start_x_reg <= first_x_reg;
                                start_y_reg <= first_y_reg;
                                cur_x_reg   <= first_x_reg;
                                cur_y_reg   <= first_y_reg;
                                dir_reg     <= '0;
                                phase_reg   <= PH_TRACING;
                            end
                            else
                            begin
                                phase_reg <= PH_EMPTY;
                            end
                        end
                    end
                    ACT_RETURN:
                    begin
                        cur_x_reg <= start_x_reg;
                        cur_y_reg <= start_y_reg;
                    end
                    ACT_MOVE:
                    begin
                        cur_x_reg <= cand_x_reg;
                        cur_y_reg <= cand_y_reg;
                        dir_reg   <= cand_d_reg + 3'd6;
                    end
                    ACT_POINT:
                    begin
                        if (out_free && is_closing)
                            phase_reg <= PH_DONE;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Probe pipeline: issue one neighbor read per cycle, test the previous one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_k_reg      <= '0;
            cand_valid_reg <= 1'b0;
        end
        else if (act == ACT_SETUP)
        begin
            iss_k_reg      <= '0;
            cand_valid_reg <= 1'b0;
        end
        else if (issue)
        begin
            iss_k_reg      <= iss_k_reg + 4'd1;
            cand_valid_reg <= 1'b1;
        end
        else
        begin
            cand_valid_reg <= 1'b0;
        end
    end

    // Hold candidate payload
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            cand_ok_reg <= in_range && before_load;
            cand_x_reg  <= tx[COORD_W-1:0];
            cand_y_reg  <= ty[COORD_W-1:0];
            cand_d_reg  <= probe_d;
        end
    end

    // Output slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free && ((act == ACT_POINT) || (act == ACT_STATUS)))
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && (act == ACT_POINT))
        begin
            out_x_reg       <= cur_x_reg;
            out_y_reg       <= cur_y_reg;
            out_closing_reg <= is_closing;
            out_status_reg  <= STS_POINT;
        end
        else if (out_free && (act == ACT_STATUS))
        begin
            out_x_reg       <= '0;
            out_y_reg       <= '0;
            out_closing_reg <= 1'b0;
            out_status_reg  <= (phase_reg == PH_EMPTY) ? STS_EMPTY : STS_DONE;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign out_closing = out_closing_reg;
    assign out_status  = out_status_reg;

endmodule

@@ src/moore_boundary_tracer.sv @@
// Moore-neighbor boundary tracer, 8-connected. Load pixels row-major with
// s_tuser low; the first pixel of an image sets the background, and a load
// after tracing has begun starts a new image. Send requests with s_tuser high:
// each returns one boundary point of the first foreground object in scan order,
// m_tlast marks the start point that closes the contour, and m_tuser gives
// status (0 point, 1 no object, 2 trace finished). A point request runs six
// fixed steps (fetch, start, check, setup, hit or miss, point) and the neighbor
// probe loop, which reads the single-port foreground map once per cycle for up
// to eight neighbors and tests each read in the next cycle; a status-only
// request runs fetch, start, check and status. Results leave through an output
// register, so the next item is accepted while a result waits; a result step
// holds only while the previous result is still waiting. The map needs no
// clearing after reset: pixels not yet loaded read as background by their load
// position. Write configuration only while the block is idle.
module moore_boundary_tracer
    import mbt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [23:0] pixel
    input  logic        s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] point_x, [15:8] point_y
    output logic        m_tlast,   // closing
    output logic [1:0]  m_tuser,   // [1:0] status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data
);

    act_t                act;
    flags_t              flags;
    logic [COORD_W-1:0]  pt_x;
    logic [COORD_W-1:0]  pt_y;

    assign cfg_ready = 1'b1;

    mbt_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .act   (act)
    );

    mbt_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .act         (act),
        .flags       (flags),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_op       (s_tuser),
        .in_pixel    (s_tdata),
        .cfg_we      (cfg_valid),
        .cfg_idx     (cfg_index),
        .cfg_val     (cfg_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_x       (pt_x),
        .out_y       (pt_y),
        .out_closing (m_tlast),
        .out_status  (m_tuser)
    );

    assign m_tdata = {pt_y, pt_x};

endmodule
